>>> hdl/complex_arith_unit_assert.svh
// assertion macros shared by the complex arithmetic unit
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// implication checked on every edge outside reset
`define CAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define CAU_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

>>> hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// shared types and constants of the complex arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none
package cau_pkg;
  localparam int PartWidth = 16;
  localparam int FracBits  = 8;
  // exact products and sums of products
  localparam int ProdWidth = 2 * PartWidth + 1;
  // dividend: |num| << FracBits
  localparam int DivWidth  = ProdWidth + FracBits;
  localparam int DenWidth  = 2 * PartWidth + 1;
  // queue between front and back
  localparam int QDepth    = 4;
  localparam int QPtrW     = 2;

  localparam logic [2:0] FuncAdd = 3'd0;
  localparam logic [2:0] FuncSub = 3'd1;
  localparam logic [2:0] FuncMul = 3'd2;
  localparam logic [2:0] FuncDiv = 3'd3;
  localparam logic [2:0] FuncCmp = 3'd4;

  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_DIRECT = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  // classified word passed from front to back
  typedef struct packed {
    kind_e kind;
    logic  equal;
    logic  div_zero;
    logic  [ProdWidth-1:0] num_re; // signed: sum or product sum
    logic  [ProdWidth-1:0] num_im;
    logic  [DenWidth-1:0]  den;
  } work_t;

  // result word
  typedef struct packed {
    logic [PartWidth-1:0] res_re;
    logic [PartWidth-1:0] res_im;
    logic equal;
    logic div_zero;
    logic overflow;
  } res_t;

  // saturate a signed-magnitude value to the part range
  function automatic logic [PartWidth:0] sat_part(input logic neg,
                                                  input logic [DivWidth-1:0] mag);
    logic [DivWidth-1:0] maxp;
    logic [PartWidth-1:0] v;
    logic o;
    maxp = DivWidth'({1'b0, {(PartWidth-1){1'b1}}});
    o = 1'b0;
    if (!neg && mag > maxp) begin
      v = {1'b0, {(PartWidth-1){1'b1}}};
      o = 1'b1;
    end else if (neg && mag > maxp + DivWidth'(1)) begin
      v = {1'b1, {(PartWidth-1){1'b0}}};
      o = 1'b1;
    end else begin
      v = neg ? PartWidth'(~mag + DivWidth'(1)) : PartWidth'(mag);
    end
    return {o, v};
  endfunction
endpackage
`default_nettype wire

>>> hdl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// accepts operands, forms products and classifies the operation
// ----------------------------------------------------------------------------
`default_nettype none
module cau_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic [2:0] func_i,
  input  wire logic signed [cau_pkg::PartWidth-1:0] a_re_i,
  input  wire logic signed [cau_pkg::PartWidth-1:0] a_im_i,
  input  wire logic signed [cau_pkg::PartWidth-1:0] b_re_i,
  input  wire logic signed [cau_pkg::PartWidth-1:0] b_im_i,
  input  wire logic stall_i,
  output logic out_valid_o,
  output cau_pkg::work_t work_o
);
  localparam int PW = cau_pkg::PartWidth;
  localparam int XW = cau_pkg::ProdWidth;

  logic [2:0] func_q;
  logic signed [PW-1:0] ar_q, ai_q, br_q, bi_q;
  logic v1_q, v2_q;
  logic signed [2*PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic [2:0] func2_q;
  logic eq2_q;
  logic signed [XW-1:0] s_re_q, s_im_q;
  logic [2*PW-1:0] sq_re_q, sq_im_q;
  cau_pkg::work_t work_d, work_q;
  logic adv;

  assign adv = !(out_valid_o && stall_i);

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      out_valid_o <= v2_q;
    end
  end

  // operand capture
  always_ff @(posedge clk_i) begin
    if (adv) begin
      func_q <= func_i;
      ar_q <= a_re_i;
      ai_q <= a_im_i;
      br_q <= b_re_i;
      bi_q <= b_im_i;
    end
  end

  // products and sums
  always_ff @(posedge clk_i) begin
    if (adv) begin
      func2_q <= func_q;
      eq2_q <= (ar_q == br_q) && (ai_q == bi_q);
      p_rr_q <= ar_q * br_q;
      p_ii_q <= ai_q * bi_q;
      p_ri_q <= ar_q * bi_q;
      p_ir_q <= ai_q * br_q;
      if (func_q == cau_pkg::FuncSub) begin
        s_re_q <= XW'(ar_q) - XW'(br_q);
        s_im_q <= XW'(ai_q) - XW'(bi_q);
      end else begin
        s_re_q <= XW'(ar_q) + XW'(br_q);
        s_im_q <= XW'(ai_q) + XW'(bi_q);
      end
    end
  end

  // denominator squares, registered alongside the products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_re_q <= (2*PW)'(br_q) * (2*PW)'(br_q);
      sq_im_q <= (2*PW)'(bi_q) * (2*PW)'(bi_q);
    end
  end

  // classify and combine products
  always_comb begin
    work_d = '0;
    work_d.equal = eq2_q;
    case (func2_q)
      cau_pkg::FuncAdd, cau_pkg::FuncSub: begin
        work_d.kind = cau_pkg::KIND_DIRECT;
        work_d.num_re = s_re_q;
        work_d.num_im = s_im_q;
      end
      cau_pkg::FuncMul: begin
        work_d.kind = cau_pkg::KIND_MUL;
        work_d.num_re = XW'(p_rr_q) - XW'(p_ii_q);
        work_d.num_im = XW'(p_ri_q) + XW'(p_ir_q);
      end
      cau_pkg::FuncDiv: begin
        work_d.kind = cau_pkg::KIND_DIV;
        work_d.num_re = XW'(p_rr_q) + XW'(p_ii_q);
        work_d.num_im = XW'(p_ir_q) - XW'(p_ri_q);
      end
      default: begin
        work_d.kind = cau_pkg::KIND_ZERO;
      end
    endcase
    // divisor magnitude squared, a zero divisor gives a zero result
    work_d.den = cau_pkg::DenWidth'(sq_re_q) + cau_pkg::DenWidth'(sq_im_q);
    if ((func2_q == cau_pkg::FuncDiv) && (sq_re_q == '0) && (sq_im_q == '0)) begin
      work_d.div_zero = 1'b1;
      work_d.kind = cau_pkg::KIND_ZERO;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      work_q <= work_d;
    end
  end
  assign work_o = work_q;
endmodule
`default_nettype wire

>>> hdl/cau_fifo.sv
// ----------------------------------------------------------------------------
// cau_fifo
// short word queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
`include "complex_arith_unit_assert.svh"
module cau_fifo (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  wire cau_pkg::work_t wdata_i,
  output logic almost_full_o,
  input  wire logic rd_i,
  output logic empty_o,
  output cau_pkg::work_t rdata_o
);
  localparam int D = cau_pkg::QDepth;
  localparam int P = cau_pkg::QPtrW;

  cau_pkg::work_t mem_q [D];
  logic [P-1:0] wp_q, rp_q;
  logic [P:0] cnt_q;

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + P'(1);
      if (rd_i) rp_q <= rp_q + P'(1);
      cnt_q <= cnt_q + (P+1)'(wr_i) - (P+1)'(rd_i);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  // one slot kept for the word in flight in the front output register
  assign almost_full_o = (cnt_q >= (P+1)'(D - 1));

  `CAU_ASSERT_NEVER(a_no_overrun, clk_i, rst_ni, wr_i && !rd_i && (cnt_q == (P+1)'(D)))
  `CAU_ASSERT_NEVER(a_no_underrun, clk_i, rst_ni, rd_i && empty_o)
  `CAU_ASSERT_IMP(a_count_limit, clk_i, rst_ni, 1'b1, cnt_q <= (P+1)'(D))
endmodule
`default_nettype wire

>>> hdl/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// pipelined restoring divider, scaling and saturation
// ----------------------------------------------------------------------------
`default_nettype none
module cau_back (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire cau_pkg::work_t work_i,
  input  wire logic stall_i,
  output logic out_valid_o,
  output cau_pkg::res_t res_o
);
  localparam int XW = cau_pkg::ProdWidth;
  localparam int DW = cau_pkg::DivWidth;
  localparam int NW = cau_pkg::DenWidth;
  localparam int FB = cau_pkg::FracBits;
  // quotient bits resolved per stage
  localparam int BPS = 4;
  localparam int NST = (DW + BPS - 1) / BPS;
  // dividend register padded so every stage shift is a real quotient bit
  localparam int QW = NST * BPS;

  typedef struct packed {
    cau_pkg::kind_e kind;
    logic equal;
    logic div_zero;
    logic neg_re, neg_im;
    logic [QW-1:0] n_re, n_im; // dividend shifts into quotient
    logic [NW:0] r_re, r_im;
    logic [NW-1:0] den;
  } st_t;

  st_t st_q [NST+1];
  st_t st0;
  logic [NST:0] v_q;
  logic adv;
  logic [XW-1:0] mre, mim;

  assign adv = !(out_valid_o && stall_i);

  // entry: sign and magnitude
  always_comb begin
    mre = work_i.num_re[XW-1] ? ~work_i.num_re + XW'(1) : work_i.num_re;
    mim = work_i.num_im[XW-1] ? ~work_i.num_im + XW'(1) : work_i.num_im;
    st0 = '0;
    st0.kind = work_i.kind;
    st0.equal = work_i.equal;
    st0.div_zero = work_i.div_zero;
    st0.neg_re = work_i.num_re[XW-1];
    st0.neg_im = work_i.num_im[XW-1];
    st0.den = work_i.den;
    if (work_i.kind == cau_pkg::KIND_DIV) begin
      st0.n_re = QW'(mre) << FB;
      st0.n_im = QW'(mim) << FB;
    end else if (work_i.kind == cau_pkg::KIND_MUL) begin
      st0.n_re = QW'(mre >> FB);
      st0.n_im = QW'(mim >> FB);
    end else begin
      st0.n_re = QW'(mre);
      st0.n_im = QW'(mim);
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NST-1:0], in_valid_i};
    end
  end

  // divider stages, each resolves a few quotient bits
  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= st0;
      for (int s = 1; s <= NST; s++) begin
        automatic st_t t = st_q[s-1];
        if (t.kind == cau_pkg::KIND_DIV) begin
          for (int b = 0; b < BPS; b++) begin
            t.r_re = {t.r_re[NW-1:0], t.n_re[QW-1]};
            t.n_re = {t.n_re[QW-2:0], 1'b0};
            if (t.r_re >= {1'b0, t.den}) begin
              t.r_re = t.r_re - {1'b0, t.den};
              t.n_re[0] = 1'b1;
            end
            t.r_im = {t.r_im[NW-1:0], t.n_im[QW-1]};
            t.n_im = {t.n_im[QW-2:0], 1'b0};
            if (t.r_im >= {1'b0, t.den}) begin
              t.r_im = t.r_im - {1'b0, t.den};
              t.n_im[0] = 1'b1;
            end
          end
        end
        st_q[s] <= t;
      end
    end
  end

  // saturation and output register
  st_t fin;
  logic [cau_pkg::PartWidth:0] sre, sim;
  logic [DW-1:0] qre, qim;
  always_comb begin
    fin = st_q[NST];
    // the quotient fits in the lower bits of the padded register
    qre = DW'(fin.n_re);
    qim = DW'(fin.n_im);
    sre = cau_pkg::sat_part(fin.neg_re && (qre != '0), qre);
    sim = cau_pkg::sat_part(fin.neg_im && (qim != '0), qim);
    if (fin.kind == cau_pkg::KIND_ZERO) begin
      sre = '0;
      sim = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (adv) out_valid_o <= v_q[NST];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_o.res_re <= sre[cau_pkg::PartWidth-1:0];
      res_o.res_im <= sim[cau_pkg::PartWidth-1:0];
      res_o.equal <= fin.equal;
      res_o.div_zero <= fin.div_zero;
      res_o.overflow <= sre[cau_pkg::PartWidth] | sim[cau_pkg::PartWidth];
    end
  end
endmodule
`default_nettype wire

>>> hdl/complex_arith_unit.sv
// pipeline: 3 front registers, 1 queue write, the divider stages and 1 output register
// throughput: one word per cycle while results are popped;
// the pipelined divider resolves 4 quotient bits a stage
// the front stalls only when the queue to the back is near full
// reset: asynchronous, active low; clears all valid flags, payload is not reset
// ----------------------------------------------------------------------------
// complex_arith_unit
// complex add, subtract, multiply, divide and compare on Q8.8 parts
// ----------------------------------------------------------------------------
`default_nettype none
`include "complex_arith_unit_assert.svh"
module complex_arith_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push,
  output logic full,
  input  wire logic [2:0] func_i,
  input  wire logic signed [cau_pkg::PartWidth-1:0] a_re_i,
  input  wire logic signed [cau_pkg::PartWidth-1:0] a_im_i,
  input  wire logic signed [cau_pkg::PartWidth-1:0] b_re_i,
  input  wire logic signed [cau_pkg::PartWidth-1:0] b_im_i,
  output logic empty,
  input  wire logic pop,
  output logic signed [cau_pkg::PartWidth-1:0] res_re_o,
  output logic signed [cau_pkg::PartWidth-1:0] res_im_o,
  output logic equal_o,
  output logic div_zero_o,
  output logic overflow_o
);
  logic fv, f_stall, q_af, q_empty, q_rd, b_stall, bv;
  cau_pkg::work_t fw, qw;
  cau_pkg::res_t br;

  assign full = f_stall;
  assign f_stall = fv && q_af;

  cau_front u_front (
    .clk_i, .rst_ni, .in_valid_i(push && !full), .func_i, .a_re_i, .a_im_i,
    .b_re_i, .b_im_i, .stall_i(f_stall), .out_valid_o(fv), .work_o(fw)
  );

  cau_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(fv && !q_af), .wdata_i(fw), .almost_full_o(q_af),
    .rd_i(q_rd), .empty_o(q_empty), .rdata_o(qw)
  );

  assign q_rd = !q_empty && !b_stall;

  cau_back u_back (
    .clk_i, .rst_ni, .in_valid_i(q_rd), .work_i(qw), .stall_i(b_stall),
    .out_valid_o(bv), .res_o(br)
  );

  assign b_stall = bv && !pop;
  assign empty = !bv;
  assign res_re_o = br.res_re;
  assign res_im_o = br.res_im;
  assign equal_o = br.equal;
  assign div_zero_o = br.div_zero;
  assign overflow_o = br.overflow;

  `CAU_ASSERT_IMP(a_dz_zero, clk_i, rst_ni, !empty && div_zero_o,
                  (res_re_o == '0) && (res_im_o == '0) && !overflow_o)
  `CAU_ASSERT_IMP(a_hold, clk_i, rst_ni, !empty && !pop, ##1 !empty)
  `CAU_ASSERT_NEVER(a_full_idle, clk_i, rst_ni, full && !fv)
endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives operand words into the complex arithmetic unit with random gaps,
// pops results with random stalls and compares each result word against a
// locally computed exact fixed-point answer
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
  } operand_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [2:0] func_i = '0;
  logic signed [15:0] a_re_i = '0, a_im_i = '0, b_re_i = '0, b_im_i = '0;
  wire logic full, empty, equal_o, div_zero_o, overflow_o;
  wire logic signed [15:0] res_re_o, res_im_o;

  operand_word_t   operand_q[$];
  cau_pkg::res_t   answer_q[$];
  bit              stim_done = 1'b0;
  int              errors = 0;
  int              cycle = 0;

  complex_arith_unit dut (
    .clk_i, .rst_ni, .push, .full, .func_i, .a_re_i, .a_im_i, .b_re_i, .b_im_i,
    .empty, .pop, .res_re_o, .res_im_o, .equal_o, .div_zero_o, .overflow_o
  );

  always #5 clk_i = ~clk_i;

  // clamp an exact value to the part range
  function automatic logic [16:0] clamp_part(input longint v);
    if (v > 32767) return {1'b1, 16'h7fff};
    if (v < -32768) return {1'b1, 16'h8000};
    return {1'b0, v[15:0]};
  endfunction

  // truncating divide of num * 2^8 by den, result clamped
  function automatic longint trunc_quot(input longint num, input longint den);
    longint q;
    q = ((num < 0 ? -num : num) << 8) / den;
    if (q > 40000) q = 40000;
    return num < 0 ? -q : q;
  endfunction

  // expected result word for one operand word
  function automatic cau_pkg::res_t complex_answer(input operand_word_t w);
    cau_pkg::res_t r;
    longint ar, ai, br, bi, xr, xi, den;
    logic [16:0] cr, ci;
    ar = w.a_re; ai = w.a_im; br = w.b_re; bi = w.b_im;
    r = '0;
    r.equal = (ar == br) && (ai == bi);
    xr = 0; xi = 0;
    case (w.func)
      cau_pkg::FuncAdd: begin xr = ar + br; xi = ai + bi; end
      cau_pkg::FuncSub: begin xr = ar - br; xi = ai - bi; end
      cau_pkg::FuncMul: begin
        xr = ar * br - ai * bi;
        xi = ar * bi + ai * br;
        xr = xr < 0 ? -((-xr) >>> 8) : xr >>> 8;
        xi = xi < 0 ? -((-xi) >>> 8) : xi >>> 8;
      end
      cau_pkg::FuncDiv: begin
        den = br * br + bi * bi;
        if (den == 0) r.div_zero = 1'b1;
        else begin
          xr = trunc_quot(ar * br + ai * bi, den);
          xi = trunc_quot(ai * br - ar * bi, den);
        end
      end
      default: ;
    endcase
    cr = clamp_part(xr);
    ci = clamp_part(xi);
    r.res_re = cr[15:0];
    r.res_im = ci[15:0];
    r.overflow = cr[16] | ci[16];
    return r;
  endfunction

  // random part value, biased toward extremes and small values
  function automatic logic [15:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 16'(16'h7fff - $urandom_range(0, 2));
      1: return 16'(16'h8000 + $urandom_range(0, 2));
      2: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // idle with odds of about 20 in 100, none in a quiet window
  function automatic bit take_gap();
    if (cycle > 800 && cycle < 1400) return 1'b0;
    return $urandom_range(0, 99) < 20;
  endfunction

  // driver: one word per accepted push
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rst_ni) begin
      if (push && !full) begin
        answer_q.push_back(complex_answer({func_i, a_re_i, a_im_i, b_re_i, b_im_i}));
      end
      if (!(push && full)) begin
        if (operand_q.size() != 0 && !take_gap()) begin
          operand_word_t w;
          w = operand_q.pop_front();
          push <= 1'b1;
          {func_i, a_re_i, a_im_i, b_re_i, b_im_i} <= w;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each popped word with the oldest answer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected word re=%0d im=%0d", $time, res_re_o, res_im_o);
          errors++;
        end else begin
          cau_pkg::res_t e;
          e = answer_q.pop_front();
          if ({res_re_o, res_im_o, equal_o, div_zero_o, overflow_o} !== e) begin
            $display("%0t: mismatch expected re=%0d im=%0d eq=%b dz=%b ov=%b",
                     $time, $signed(e.res_re), $signed(e.res_im), e.equal,
                     e.div_zero, e.overflow);
            $display("%0t:          actual   re=%0d im=%0d eq=%b dz=%b ov=%b",
                     $time, res_re_o, res_im_o, equal_o, div_zero_o, overflow_o);
            errors++;
          end
        end
      end
      pop <= !take_gap();
    end
  end

  // stimulus and end of run
  initial begin
    operand_word_t w;
    // directed: extremes for every func, divide by zero, compare, unused codes
    for (int f = 0; f < 8; f++) begin
      operand_q.push_back({3'(f), 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000});
      operand_q.push_back({3'(f), -16'sh8000, -16'sh8000, -16'sh8000, 16'sh7fff});
    end
    operand_q.push_back({cau_pkg::FuncDiv, 16'sh0100, 16'sh0200, 16'sh0000, 16'sh0000});
    operand_q.push_back({cau_pkg::FuncDiv, 16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh0001});
    operand_q.push_back({cau_pkg::FuncDiv, -16'sh8000, 16'sh0000, 16'sh0001, 16'sh0000});
    operand_q.push_back({cau_pkg::FuncCmp, 16'sh0100, 16'sh0200, 16'sh0100, 16'sh0201});
    operand_q.push_back({cau_pkg::FuncMul, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000});
    operand_q.push_back({cau_pkg::FuncMul, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
    // random words, mostly legal codes
    for (int i = 0; i < 1950; i++) begin
      w.func = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      w.a_re = rand_part(); w.a_im = rand_part();
      if ($urandom_range(0, 7) == 0) begin
        w.b_re = w.a_re; w.b_im = w.a_im;
      end else begin
        w.b_re = rand_part(); w.b_im = rand_part();
      end
      if (w.func == cau_pkg::FuncDiv && $urandom_range(0, 9) == 0) w.b_im = 16'sh0000;
      operand_q.push_back(w);
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (operand_q.size() == 0 && !push);
    wait (answer_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
+incdir+hdl
hdl/cau_pkg.sv
hdl/cau_front.sv
hdl/cau_fifo.sv
hdl/cau_back.sv
hdl/complex_arith_unit.sv
verif/testbench.sv
